[rtl/per_flow_token_bucket_limiter_core_assert.svh]
// Assertion macros for the token bucket limiter
`ifndef PER_FLOW_TOKEN_BUCKET_LIMITER_CORE_ASSERT_SVH
`define PER_FLOW_TOKEN_BUCKET_LIMITER_CORE_ASSERT_SVH
`define TBL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TBL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[rtl/tbl_pkg.sv]
// ----------------------------------------------------------------------------
// tbl_pkg
// Types and constants shared by the token bucket limiter.
// ----------------------------------------------------------------------------
package tbl_pkg;
   localparam int TABLE_ENTRIES = 64;
   localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int COUNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [7:0] FLAG_SYN = 8'h02;
   localparam logic [7:0] FLAG_ACK = 8'h10;
   localparam logic [2:0] OUT_NOT_ELIGIBLE = 3'd0;
   localparam logic [2:0] OUT_NEW_BUCKET = 3'd1;
   localparam logic [2:0] OUT_SPENT = 3'd2;
   localparam logic [2:0] OUT_DROPPED = 3'd3;
   localparam logic [2:0] OUT_TABLE_FULL = 3'd4;
   localparam logic CSR_BURST = 1'b0;
   localparam logic CSR_NS = 1'b1;
   localparam int KEY_W = 104;
   localparam int ENTRY_W = KEY_W + 16 + 64;

   typedef struct packed {
      logic [31:0] src_address;
      logic [63:0] group_id;
      logic [7:0]  protocol;
      logic [7:0]  tcp_flag_bits;
      logic [63:0] timestamp_ns;
   } req_type;

   typedef struct packed {
      logic       allow;
      logic [2:0] outcome;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_sts_type;
endpackage

[rtl/tbl_ram.sv]
// ----------------------------------------------------------------------------
// tbl_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                             wr_data,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_ff <= mem_ff[addr];
   end

   assign rd_data = rd_ff;
endmodule

[rtl/tbl_divider.sv]
// ----------------------------------------------------------------------------
// tbl_divider
// Restoring divider, 64 by 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbl_divider
   import tbl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_sts_type sts
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      trial = {rem_ff, quo_ff[63]};
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         quo_in = cmd.dividend;
         rem_in = '0;
         dvs_in = cmd.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 32'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign sts.done = done_ff;
   assign sts.quotient = quo_ff;
endmodule

[rtl/per_flow_token_bucket_limiter_core.sv]
// Steps per item: an ineligible packet goes straight to its result; a new flow
//   or a full table walks every used slot through the registered RAM read; a
//   known flow walks the slots up to its own, then, if the ns-per-token setting
//   is not zero, waits on the shared divider.
// Throughput: one item at a time; req_stall is high until its result beat leaves.
// Reset: synchronous; clears the slot fill count and restores the state and CSR defaults.
// ----------------------------------------------------------------------------
// per_flow_token_bucket_limiter_core
// Per-flow token bucket limiter with a serial table walk and shared divider.
// ----------------------------------------------------------------------------
module per_flow_token_bucket_limiter_core
   import tbl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);
   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_CMP, S_DIV, S_UPD, S_OUT
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   rsp_type            rsp_ff, rsp_in;
   logic [15:0]        burst_ff, burst_in;
   logic [31:0]        nspt_ff, nspt_in;
   logic [COUNT_W-1:0] used_ff, used_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic               we;
   logic [SLOT_W-1:0]  addr;
   logic [ENTRY_W-1:0] wdata, rdata;
   div_cmd_type        dcmd;
   div_sts_type        dsts;
   logic [KEY_W-1:0]   key;
   logic [15:0]        ent_tok, tok;
   logic [63:0]        ent_time;
   logic               elig;
   logic [16:0]        sum;

   tbl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
      .clock(clock), .wr_en(we), .addr(addr), .wr_data(wdata), .rd_data(rdata)
   );
   tbl_divider u_div (.clock(clock), .reset(reset), .cmd(dcmd), .sts(dsts));

   assign key = {req_ff.src_address, req_ff.group_id, req_ff.protocol};
   assign ent_tok = rdata[79:64];
   assign ent_time = rdata[63:0];
   assign addr = idx_ff[SLOT_W-1:0];
   assign csr_ready = (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      burst_in = burst_ff;
      nspt_in = nspt_ff;
      used_in = used_ff;
      idx_in = idx_ff;
      we = 1'b0;
      wdata = {key, ent_tok, ent_time};
      dcmd = '0;
      dcmd.dividend = req_ff.timestamp_ns - ent_time;
      dcmd.divisor = nspt_ff;
      tok = ent_tok;
      sum = '0;
      elig = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               if (csr_index == CSR_BURST) burst_in = csr_data[15:0];
               else nspt_in = csr_data;
            end
            if (req_valid) begin
               req_in = req_data;
               idx_in = '0;
               if (req_data.protocol == PROTO_TCP)
                  elig = (req_data.tcp_flag_bits & FLAG_SYN) != 8'd0 &&
                         (req_data.tcp_flag_bits & FLAG_ACK) == 8'd0;
               else
                  elig = req_data.protocol == PROTO_UDP ||
                         req_data.protocol == PROTO_ICMP;
               if (!elig) begin
                  rsp_in = '{allow: 1'b1, outcome: OUT_NOT_ELIGIBLE};
                  state_in = S_OUT;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            if (idx_ff >= used_ff) begin
               if (used_ff == COUNT_W'(TABLE_ENTRIES)) begin
                  rsp_in = '{allow: 1'b1, outcome: OUT_TABLE_FULL};
               end else begin
                  we = 1'b1;
                  wdata = {key, (burst_ff == 16'd0) ? 16'd0 : burst_ff - 16'd1,
                           req_ff.timestamp_ns};
                  used_in = used_ff + COUNT_W'(1);
                  rsp_in = '{allow: 1'b1, outcome: OUT_NEW_BUCKET};
               end
               state_in = S_OUT;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (rdata[ENTRY_W-1:80] == key) begin
               if (nspt_ff != 32'd0) begin
                  dcmd.start = 1'b1;
                  state_in = S_DIV;
               end else begin
                  state_in = S_UPD;
               end
            end else begin
               idx_in = idx_ff + COUNT_W'(1);
               state_in = S_READ;
            end
         end
         S_DIV: begin
            if (dsts.done) state_in = S_UPD;
         end
         S_UPD: begin
            wdata = {key, ent_tok, ent_time};
            if (nspt_ff != 32'd0 && dsts.quotient != 64'd0) begin
               if (dsts.quotient >= {48'd0, burst_ff}) tok = burst_ff;
               else begin
                  sum = {1'b0, ent_tok} + {1'b0, dsts.quotient[15:0]};
                  tok = (sum > {1'b0, burst_ff}) ? burst_ff : sum[15:0];
               end
               wdata[63:0] = req_ff.timestamp_ns;
            end
            if (tok == 16'd0) begin
               rsp_in = '{allow: 1'b0, outcome: OUT_DROPPED};
            end else begin
               tok = tok - 16'd1;
               rsp_in = '{allow: 1'b1, outcome: OUT_SPENT};
            end
            wdata[79:64] = tok;
            we = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         burst_ff <= 16'd10;
         nspt_ff <= 32'd1000000;
         used_ff <= '0;
      end else begin
         state_ff <= state_in;
         burst_ff <= burst_in;
         nspt_ff <= nspt_in;
         used_ff <= used_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      idx_ff <= idx_in;
   end
endmodule

[rtl/tbl_checker.sv]
// ----------------------------------------------------------------------------
// tbl_checker
// Port-level checks of the token bucket limiter.
// ----------------------------------------------------------------------------
`include "per_flow_token_bucket_limiter_core_assert.svh"
module tbl_checker
   import tbl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data,
   input logic    csr_ready
);
   `TBL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `TBL_ASSERT_IMPL(a_no_rsp_when_open, clock, reset, !req_stall, !rsp_valid)
   `TBL_ASSERT_IMPL(a_csr_when_open, clock, reset, csr_ready, !req_stall)
   `TBL_ASSERT_IMPL(a_drop_code, clock, reset, rsp_valid && !rsp_data.allow, rsp_data.outcome == OUT_DROPPED)
   `TBL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
endmodule

bind per_flow_token_bucket_limiter_core tbl_checker u_tbl_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
   .csr_ready(csr_ready)
);
